// ----- sv/ipdfs_pkg.sv -----
package ipdfs_pkg;

   // Default sizes
   localparam int BUFFER_BITS_DEFAULT = 256;
   localparam int FRAME_BITS_DEFAULT  = 14;

   // Field and register widths
   localparam int KIND_W   = 1;
   localparam int TYPE_W   = 3;
   localparam int ROBOT_W  = 4;
   localparam int ARG_W    = 7;
   localparam int TICKS_W  = 16;
   localparam int BITS_W   = 5;
   localparam int CSR_IDX_W = 4;

   // Frame layout: type above robot above argument
   localparam int ROBOT_SHIFT = ARG_W;
   localparam int TYPE_SHIFT  = ARG_W + ROBOT_W;
   localparam int PACKED_W    = TYPE_SHIFT + TYPE_W;

   // Register reset values
   localparam logic [TICKS_W-1:0] HEADER_TICKS_RESET = 16'd8;
   localparam logic [TICKS_W-1:0] PAUSE_TICKS_RESET  = 16'd1;
   localparam logic [TICKS_W-1:0] ONE_TICKS_RESET    = 16'd3;
   localparam logic [TICKS_W-1:0] ZERO_TICKS_RESET   = 16'd1;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_HEADER_TICKS = 4'd0,
      REG_PAUSE_TICKS  = 4'd1,
      REG_ONE_TICKS    = 4'd2,
      REG_ZERO_TICKS   = 4'd3
   } reg_index_type;

   // Item kinds
   typedef enum logic [KIND_W-1:0] {
      OP_TICK    = 1'b0,
      OP_ENQUEUE = 1'b1
   } op_type;

   // Queue head status seen by the back end
   typedef struct packed {
      logic   not_empty;
      op_type op;
   } queue_status_type;

endpackage

// ----- sv/ipdfs_if.sv -----
interface ipdfs_req_if
   import ipdfs_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [TYPE_W-1:0]  frame_type;
   logic [ROBOT_W-1:0] robot_id;
   logic [ARG_W-1:0]   argument;

   modport source (output valid, kind, frame_type, robot_id, argument, input ready);
   modport sink   (input valid, kind, frame_type, robot_id, argument, output ready);
endinterface

interface ipdfs_rsp_if;
   logic valid;
   logic ready;
   logic carrier_on;
   logic frame_marker;

   modport source (output valid, carrier_on, frame_marker, input ready);
   modport sink   (input valid, carrier_on, frame_marker, output ready);
endinterface

// ----- sv/ipdfs_front.sv -----
module ipdfs_front
   import ipdfs_pkg::*;
#(
   parameter int FRAME_BITS = FRAME_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   ipdfs_req_if.sink             req_bus,
   output queue_status_type      q_status,
   output logic [FRAME_BITS-1:0] q_frame,
   input  logic                  q_pop
);

   localparam int DEPTH = 2;

   op_type                slot_op_ff    [DEPTH];
   logic [FRAME_BITS-1:0] slot_frame_ff [DEPTH];
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   logic [1:0]            count_ff, count_in;
   logic                  push;
   op_type                op_in;
   logic [FRAME_BITS-1:0] frame_in;

   // Classify the word and pack the frame
   always_comb begin
      op_in    = op_type'(req_bus.kind);
      frame_in = FRAME_BITS'({req_bus.frame_type, req_bus.robot_id, req_bus.argument});
   end

   assign req_bus.ready = (count_ff != 2'(DEPTH));
   assign push          = req_bus.valid && req_bus.ready;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold queued words
   always_ff @(posedge clock) begin
      if (push) begin
         slot_op_ff[wr_ptr_ff]    <= op_in;
         slot_frame_ff[wr_ptr_ff] <= frame_in;
      end
   end

   assign q_status.not_empty = (count_ff != 2'd0);
   assign q_status.op        = slot_op_ff[rd_ptr_ff];
   assign q_frame            = slot_frame_ff[rd_ptr_ff];

endmodule

// ----- sv/ipdfs_back.sv -----
module ipdfs_back
   import ipdfs_pkg::*;
#(
   parameter int BUFFER_BITS = BUFFER_BITS_DEFAULT,
   parameter int FRAME_BITS  = FRAME_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  queue_status_type      q_status,
   input  logic [FRAME_BITS-1:0] q_frame,
   output logic                  q_pop,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [TICKS_W-1:0]    csr_wdata,
   ipdfs_rsp_if.source           rsp_bus
);

   localparam int PTR_W = $clog2(BUFFER_BITS);
   localparam int CNT_W = $clog2(FRAME_BITS);
   localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(BUFFER_BITS - 1);
   localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(FRAME_BITS - 1);
   localparam logic [BITS_W-1:0] BITS_FULL = BITS_W'(FRAME_BITS);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_WRITE = 4'b0010,
      ST_FETCH = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [TICKS_W-1:0]    header_ticks_ff, pause_ticks_ff, one_ticks_ff, zero_ticks_ff;
   logic                  mem [BUFFER_BITS];
   logic                  rd_data_ff;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [FRAME_BITS-1:0] shift_ff, shift_in;
   logic [CNT_W-1:0]      bit_cnt_ff, bit_cnt_in;
   logic [TICKS_W-1:0]    countdown_ff, countdown_in;
   logic [BITS_W-1:0]     bits_left_ff, bits_left_in;
   logic                  mark_ff, mark_in;
   logic                  after_header_ff, after_header_in;
   logic                  marker_ff, marker_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  carrier_out_ff, marker_out_ff;
   logic                  mem_we;
   logic                  out_free;
   logic                  load_out;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         header_ticks_ff <= HEADER_TICKS_RESET;
         pause_ticks_ff  <= PAUSE_TICKS_RESET;
         one_ticks_ff    <= ONE_TICKS_RESET;
         zero_ticks_ff   <= ZERO_TICKS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_HEADER_TICKS: header_ticks_ff <= csr_wdata;
            REG_PAUSE_TICKS:  pause_ticks_ff  <= csr_wdata;
            REG_ONE_TICKS:    one_ticks_ff    <= csr_wdata;
            REG_ZERO_TICKS:   zero_ticks_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign mem_we   = (state_ff == ST_WRITE);

   // Sequence the back end
   always_comb begin
      state_in        = state_ff;
      q_pop           = 1'b0;
      load_out        = 1'b0;
      rd_ptr_in       = rd_ptr_ff;
      wr_ptr_in       = wr_ptr_ff;
      shift_in        = shift_ff;
      bit_cnt_in      = bit_cnt_ff;
      countdown_in    = countdown_ff;
      bits_left_in    = bits_left_ff;
      mark_in         = mark_ff;
      after_header_in = after_header_ff;
      marker_in       = marker_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_status.not_empty) begin
               q_pop = 1'b1;
               if (q_status.op == OP_ENQUEUE) begin
                  shift_in   = q_frame;
                  bit_cnt_in = '0;
                  state_in   = ST_WRITE;
               end else begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_WRITE: begin
            // Store one bit a cycle, most significant first
            shift_in   = {shift_ff[FRAME_BITS-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + 1'b1;
            wr_ptr_in  = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
            if (bit_cnt_ff == CNT_LAST) begin
               state_in = ST_EMIT;
            end
         end
         ST_FETCH: begin
            // Advance the carrier timing by one tick
            if (countdown_ff != '0) begin
               countdown_in = countdown_ff - 1'b1;
            end else if (mark_ff) begin
               countdown_in = pause_ticks_ff;
               mark_in      = 1'b0;
            end else if ((rd_ptr_ff == wr_ptr_ff) || (bits_left_ff == '0)) begin
               countdown_in    = header_ticks_ff;
               mark_in         = 1'b1;
               bits_left_in    = BITS_FULL;
               after_header_in = 1'b1;
            end else begin
               marker_in       = after_header_ff;
               rd_ptr_in       = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
               countdown_in    = rd_data_ff ? one_ticks_ff : zero_ticks_ff;
               after_header_in = 1'b0;
               bits_left_in    = bits_left_ff - 1'b1;
               mark_in         = 1'b1;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load_out ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rd_ptr_ff       <= '0;
         wr_ptr_ff       <= '0;
         bit_cnt_ff      <= '0;
         countdown_ff    <= HEADER_TICKS_RESET;
         bits_left_ff    <= BITS_FULL;
         mark_ff         <= 1'b1;
         after_header_ff <= 1'b1;
         marker_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         rd_ptr_ff       <= rd_ptr_in;
         wr_ptr_ff       <= wr_ptr_in;
         bit_cnt_ff      <= bit_cnt_in;
         countdown_ff    <= countdown_in;
         bits_left_ff    <= bits_left_in;
         mark_ff         <= mark_in;
         after_header_ff <= after_header_in;
         marker_ff       <= marker_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Hold the frame shifter and the result word
   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      if (load_out) begin
         carrier_out_ff <= mark_ff;
         marker_out_ff  <= marker_ff;
      end
   end

   // Bit ring buffer with registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_ptr_ff] <= shift_ff[FRAME_BITS-1];
      end
      rd_data_ff <= mem[rd_ptr_ff];
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.carrier_on   = carrier_out_ff;
   assign rsp_bus.frame_marker = marker_out_ff;

endmodule

// ----- sv/ir_pulse_distance_frame_sender_core.sv -----
// Tick word: dequeue with buffer read, update, output. Enqueue word: the back end
// writes one frame bit per cycle into the bit buffer, which has a write port and a
// separate registered read port, and then outputs a result. One word is in work at a time;
// a 2-entry queue and the output register let the input and result sides stall independently.
// Reset (synchronous, active high) clears pointers and sequencer and loads the configuration
// registers; the bit buffer is never read before being written.
module ir_pulse_distance_frame_sender_core
   import ipdfs_pkg::*;
#(
   parameter int BUFFER_BITS = BUFFER_BITS_DEFAULT,
   parameter int FRAME_BITS  = FRAME_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   ipdfs_req_if.sink            req_bus,
   ipdfs_rsp_if.source          rsp_bus,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TICKS_W-1:0]   csr_wdata
);

   queue_status_type      q_status;
   logic [FRAME_BITS-1:0] q_frame;
   logic                  q_pop;

   // Accept and classify words
   ipdfs_front #(
      .FRAME_BITS (FRAME_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .q_status (q_status),
      .q_frame  (q_frame),
      .q_pop    (q_pop)
   );

   // Store bits and drive the carrier timing
   ipdfs_back #(
      .BUFFER_BITS (BUFFER_BITS),
      .FRAME_BITS  (FRAME_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_frame   (q_frame),
      .q_pop     (q_pop),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_bus   (rsp_bus)
   );

endmodule

// ----- test/tb_ir_pulse_distance_frame_sender_core.sv -----
`timescale 1ns / 1ps

module tb_ir_pulse_distance_frame_sender_core;
   import ipdfs_pkg::*;

   localparam int BUF_BITS   = BUFFER_BITS_DEFAULT;
   localparam int FRM_BITS   = FRAME_BITS_DEFAULT;
   localparam int PTR_W      = $clog2(BUF_BITS);
   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 8;
   localparam logic [TICKS_W-1:0] TICKS_MAX = '1;
   localparam logic [PTR_W-1:0]   PTR_LAST  = PTR_W'(BUF_BITS - 1);

   typedef struct packed {
      logic carrier_on;
      logic frame_marker;
   } levels_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [TICKS_W-1:0] csr_wdata;

   ipdfs_req_if req_bus ();
   ipdfs_rsp_if rsp_bus ();

   ir_pulse_distance_frame_sender_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Sender state mirror
   logic [TICKS_W-1:0] header_len, pause_len, one_len, zero_len;
   logic               bit_ring [BUF_BITS];
   logic [PTR_W-1:0]   rd_ptr, wr_ptr;
   logic [TICKS_W-1:0] countdown;
   logic [BITS_W-1:0]  bits_left;
   logic               mark_on, after_header, marker_level;

   levels_type expected_levels [$];
   int      mismatch_count;
   int      send_idle_pct, recv_idle_pct;
   int      quiet_cycles;

   // Clock
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Advance the sender by one word and return the resulting output levels
   function automatic levels_type advance_sender(op_type op, logic [TYPE_W-1:0] ftype,
                                                 logic [ROBOT_W-1:0] rid,
                                                 logic [ARG_W-1:0] arg);
      logic [PACKED_W-1:0] frame;
      logic                next_bit;
      levels_type          lv;
      if (op == OP_ENQUEUE) begin
         frame = {ftype, rid, arg};
         for (int pos = FRM_BITS - 1; pos >= 0; pos--) begin
            bit_ring[wr_ptr] = (pos < PACKED_W) ? frame[pos] : 1'b0;
            wr_ptr = (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
         end
      end else if (countdown != '0) begin
         countdown = countdown - 1'b1;
      end else if (mark_on) begin
         countdown = pause_len;
         mark_on = 1'b0;
      end else if (rd_ptr == wr_ptr || bits_left == '0) begin
         // empty buffer or finished frame: header mark
         countdown = header_len;
         mark_on = 1'b1;
         bits_left = BITS_W'(FRM_BITS);
         after_header = 1'b1;
      end else begin
         marker_level = after_header;
         next_bit = bit_ring[rd_ptr];
         rd_ptr = (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
         countdown = next_bit ? one_len : zero_len;
         after_header = 1'b0;
         bits_left = bits_left - 1'b1;
         mark_on = 1'b1;
      end
      lv.carrier_on = mark_on;
      lv.frame_marker = marker_level;
      return lv;
   endfunction

   // Send one word; valid stays high into the next call unless it idles
   task automatic send_word(op_type op, logic [TYPE_W-1:0] ftype,
                            logic [ROBOT_W-1:0] rid, logic [ARG_W-1:0] arg);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.kind       <= op;
      req_bus.frame_type <= ftype;
      req_bus.robot_id   <= rid;
      req_bus.argument   <= arg;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      expected_levels.push_back(advance_sender(op, ftype, rid, arg));
   endtask

   task automatic send_tick();
      send_word(OP_TICK, TYPE_W'($urandom), ROBOT_W'($urandom), ARG_W'($urandom));
   endtask

   task automatic send_frame();
      send_word(OP_ENQUEUE, TYPE_W'($urandom), ROBOT_W'($urandom), ARG_W'($urandom));
   endtask

   // Drop valid and wait until every result is back
   task automatic settle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_levels.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [TICKS_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (idx)
         REG_HEADER_TICKS: header_len = value;
         REG_PAUSE_TICKS:  pause_len  = value;
         REG_ONE_TICKS:    one_len    = value;
         REG_ZERO_TICKS:   zero_len   = value;
         default: ;
      endcase
   endtask

   // Mostly short lengths so phases move; zero now and then
   function automatic logic [TICKS_W-1:0] pick_ticks();
      int roll;
      roll = $urandom_range(99);
      if (roll < 10) return '0;
      if (roll < 75) return TICKS_W'($urandom_range(4, 1));
      return TICKS_W'($urandom_range(12, 5));
   endfunction

   task automatic load_random_regs();
      write_reg(REG_HEADER_TICKS, pick_ticks());
      write_reg(REG_PAUSE_TICKS, pick_ticks());
      write_reg(REG_ONE_TICKS, pick_ticks());
      write_reg(REG_ZERO_TICKS, pick_ticks());
   endtask

   // Reset lengths, empty-buffer headers, field extremes in both directions
   task automatic test_directed_frames();
      repeat (3) send_tick();
      send_word(OP_ENQUEUE, '0, '0, '0);
      send_word(OP_ENQUEUE, '1, '1, '1);
      send_word(OP_ENQUEUE, TYPE_W'(5), ROBOT_W'(10), ARG_W'(7'h2A));
      repeat (19) send_tick();
      settle();
   endtask

   // All lengths at zero; writes to unused indexes must be ignored
   task automatic test_zero_lengths();
      write_reg(REG_HEADER_TICKS, '0);
      write_reg(REG_PAUSE_TICKS, '0);
      write_reg(REG_ONE_TICKS, '0);
      write_reg(REG_ZERO_TICKS, '0);
      for (int idx = int'(REG_ZERO_TICKS) + 1; idx < 2 ** CSR_IDX_W; idx++)
         write_reg(CSR_IDX_W'(idx), TICKS_W'($urandom));
      send_frame();
      send_frame();
      repeat (40) send_tick();
      settle();
   endtask

   // Overrun the ring: the write pointer laps the read pointer
   task automatic test_ring_overrun();
      repeat (20) send_frame();
      repeat (60) send_tick();
      settle();
   endtask

   task automatic test_random_traffic(int words, int snd_pct, int rcv_pct);
      send_idle_pct = snd_pct;
      recv_idle_pct = rcv_pct;
      for (int n = 0; n < words; n++) begin
         if (n % 100 == 0) begin
            settle();
            load_random_regs();
         end
         if ($urandom_range(99) < 4)
            send_frame();
         else
            send_tick();
      end
      settle();
   endtask

   // Largest lengths: load one and run down part of it
   task automatic test_max_lengths();
      int guard;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_reg(REG_HEADER_TICKS, TICKS_MAX);
      write_reg(REG_PAUSE_TICKS, TICKS_MAX);
      write_reg(REG_ONE_TICKS, TICKS_MAX);
      write_reg(REG_ZERO_TICKS, TICKS_MAX);
      send_frame();
      guard = 0;
      while (countdown < TICKS_MAX - 16'd100 && guard < 200) begin
         send_tick();
         guard++;
      end
      repeat (40) send_tick();
      settle();
   endtask

   // Result checker
   always @(posedge clock) begin
      levels_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_levels.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected word, expected none, actual carrier_on=%b frame_marker=%b",
                     $time, rsp_bus.carrier_on, rsp_bus.frame_marker);
         end else begin
            want = expected_levels.pop_front();
            if (rsp_bus.carrier_on !== want.carrier_on) begin
               mismatch_count++;
               $display("%0t: carrier_on expected %b actual %b",
                        $time, want.carrier_on, rsp_bus.carrier_on);
            end
            if (rsp_bus.frame_marker !== want.frame_marker) begin
               mismatch_count++;
               $display("%0t: frame_marker expected %b actual %b",
                        $time, want.frame_marker, rsp_bus.frame_marker);
            end
         end
      end
   end

   // Result-side stalls
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      // Drive every input and load the reset state
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      req_bus.valid      = 1'b0;
      req_bus.kind       = OP_TICK;
      req_bus.frame_type = '0;
      req_bus.robot_id   = '0;
      req_bus.argument   = '0;
      rsp_bus.ready      = 1'b0;
      quiet_cycles       = 0;
      mismatch_count     = 0;
      send_idle_pct      = 0;
      recv_idle_pct      = 0;
      header_len         = HEADER_TICKS_RESET;
      pause_len          = PAUSE_TICKS_RESET;
      one_len            = ONE_TICKS_RESET;
      zero_len           = ZERO_TICKS_RESET;
      rd_ptr             = '0;
      wr_ptr             = '0;
      countdown          = HEADER_TICKS_RESET;
      bits_left          = BITS_W'(FRM_BITS);
      mark_on            = 1'b1;
      after_header       = 1'b1;
      marker_level       = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_frames();
      test_zero_lengths();
      test_ring_overrun();
      test_random_traffic(450, 37, 82);
      test_random_traffic(450, 82, 37);
      test_random_traffic(450, 0, 0);
      test_max_lengths();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_levels.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
